@@ sv/nidv_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared types, constants and lookup functions for the ID number validator.
package nidv_pkg;

  typedef logic [4:0] pos_t;
  typedef logic [3:0] sum_t;
  typedef logic [6:0] val_t;
  typedef logic [3:0] digit_t;
  typedef logic [1:0] status_t;

  // Two-digit birth date fields, handed to the date checker
  typedef struct packed {
    val_t century;
    val_t year;
    val_t month;
    val_t day;
  } date_t;

  localparam pos_t ID_LEN   = 5'd18;
  localparam pos_t BODY_LEN = 5'd17;

  localparam pos_t POS_CENT_HI = 5'd6;
  localparam pos_t POS_CENT_LO = 5'd7;
  localparam pos_t POS_YEAR_HI = 5'd8;
  localparam pos_t POS_YEAR_LO = 5'd9;
  localparam pos_t POS_MON_HI  = 5'd10;
  localparam pos_t POS_MON_LO  = 5'd11;
  localparam pos_t POS_DAY_HI  = 5'd12;
  localparam pos_t POS_DAY_LO  = 5'd13;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;
  localparam logic [7:0] ASCII_X    = 8'd88;

  localparam val_t MONTH_FEB  = 7'd2;
  localparam val_t MONTH_APR  = 7'd4;
  localparam val_t MONTH_JUN  = 7'd6;
  localparam val_t MONTH_SEP  = 7'd9;
  localparam val_t MONTH_NOV  = 7'd11;
  localparam val_t MONTH_MAX  = 7'd12;
  localparam val_t DAY_LEAP   = 7'd29;
  localparam val_t DAY_FEB    = 7'd28;
  localparam val_t DAY_SHORT  = 7'd30;
  localparam val_t DAY_LONG   = 7'd31;

  localparam int STAT_DATE_BIT = 0;
  localparam int STAT_CODE_BIT = 1;

  // ISO 7064 MOD 11-2 weights for characters 1..17
  function automatic sum_t weight_of(input pos_t p);
    sum_t w;
    case (p)
      5'd0:    w = 4'd7;
      5'd1:    w = 4'd9;
      5'd2:    w = 4'd10;
      5'd3:    w = 4'd5;
      5'd4:    w = 4'd8;
      5'd5:    w = 4'd4;
      5'd6:    w = 4'd2;
      5'd7:    w = 4'd1;
      5'd8:    w = 4'd6;
      5'd9:    w = 4'd3;
      5'd10:   w = 4'd7;
      5'd11:   w = 4'd9;
      5'd12:   w = 4'd10;
      5'd13:   w = 4'd5;
      5'd14:   w = 4'd8;
      5'd15:   w = 4'd4;
      5'd16:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // Expected check character for a given sum mod 11
  function automatic logic [7:0] check_char(input sum_t s);
    logic [7:0] c;
    case (s)
      4'd0:    c = 8'd49;      // '1'
      4'd1:    c = 8'd48;      // '0'
      4'd2:    c = ASCII_X;
      4'd3:    c = 8'd57;
      4'd4:    c = 8'd56;
      4'd5:    c = 8'd55;
      4'd6:    c = 8'd54;
      4'd7:    c = 8'd53;
      4'd8:    c = 8'd52;
      4'd9:    c = 8'd51;
      4'd10:   c = 8'd50;      // '2'
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // v mod 11 for v < 128: quotient by reciprocal 187/2048, exact in this range
  function automatic sum_t mod11(input val_t v);
    logic [14:0] prod;
    logic [3:0]  q;
    val_t        r;
    prod = 15'(v) * 15'd187;
    q    = prod[14:11];
    r    = v - 7'(q) * 7'd11;
    return r[3:0];
  endfunction

endpackage

@@ sv/nidv_date_chk.sv @@
`timescale 1ns / 1ps
// Birth date range check: month, days per month, Gregorian leap years.
module nidv_date_chk
  import nidv_pkg::*;
(
  input  date_t date_i,
  output logic  bad_o
);

  logic leap;
  val_t feb_max;
  logic short_month;

  // Fields are at most 99, so y%100 is the year field and y%4 its low bits;
  // y%400 == 0 only when the year field is 0 and the century is a multiple of 4.
  always_comb begin
    leap = ((date_i.year[1:0] == 2'd0) && (date_i.year != 7'd0)) ||
           ((date_i.year == 7'd0) && (date_i.century[1:0] == 2'd0));
    feb_max = leap ? DAY_LEAP : DAY_FEB;
    short_month = (date_i.month == MONTH_APR) || (date_i.month == MONTH_JUN) ||
                  (date_i.month == MONTH_SEP) || (date_i.month == MONTH_NOV);
    bad_o = (date_i.month == 7'd0) || (date_i.month > MONTH_MAX) ||
            (date_i.day == 7'd0) || (date_i.day > DAY_LONG) ||
            ((date_i.month == MONTH_FEB) && (date_i.day > feb_max)) ||
            (short_month && (date_i.day > DAY_SHORT));
  end

endmodule

@@ sv/national_id_number_validator.sv @@
`timescale 1ns / 1ps
// Top level: streaming 18-character ID number validator (MOD 11-2 check + date check).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in_     | input     | in_valid / in_ready  | in_char_code[7:0], in_line_start
//  out_    | output    | out_valid / out_ready| out_status[1:0]
//
// One character per cycle, back to back, while no waiting result stalls the
// input. An item is captured in the input register, then its sum, date and
// check work is done combinationally into the result register; out_valid
// rises once the 18th character has passed through both registers.
// Synchronous active-low reset clears position, accumulators and valid flags.
// A stalled result holds the result register and the input register behind
// it; in_ready drops while the input register is full and a waiting result
// is not taken.
module national_id_number_validator
  import nidv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_line_start,
  output logic       out_valid,
  input  logic       out_ready,
  output status_t    out_status
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_start_r;

  // per-number state
  pos_t pos_r, pos_nxt;
  sum_t sum_r, sum_nxt;
  val_t cent_r, cent_nxt;
  val_t year_r, year_nxt;
  val_t mon_r, mon_nxt;
  val_t day_r, day_nxt;
  logic nondig_r, nondig_nxt;

  // result register
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;

  logic   adv;      // input register item processed this cycle
  logic   has_res;  // that item is the check character
  pos_t   pos_b;
  sum_t   sum_b;
  val_t   cent_b, year_b, mon_b, day_b;
  logic   nondig_b;
  logic   is_digit;
  digit_t digit;
  logic [7:0] wprod;
  val_t   sum_raw;
  date_t  date;
  logic   date_bad;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // line start clears everything before the character is used
  always_comb begin
    pos_b    = s1_start_r ? 5'd0 : pos_r;
    sum_b    = s1_start_r ? 4'd0 : sum_r;
    cent_b   = s1_start_r ? 7'd0 : cent_r;
    year_b   = s1_start_r ? 7'd0 : year_r;
    mon_b    = s1_start_r ? 7'd0 : mon_r;
    day_b    = s1_start_r ? 7'd0 : day_r;
    nondig_b = s1_start_r ? 1'b0 : nondig_r;
  end

  assign is_digit = (s1_char_r >= ASCII_ZERO) && (s1_char_r <= ASCII_NINE);
  assign digit    = is_digit ? 4'(s1_char_r - ASCII_ZERO) : 4'd0;
  assign wprod    = weight_of(pos_b) * digit;
  assign sum_raw  = 7'(sum_b) + wprod[6:0];

  assign date = '{century: cent_b, year: year_b, month: mon_b, day: day_b};

  nidv_date_chk u_date_chk (
    .date_i (date),
    .bad_o  (date_bad)
  );

  assign has_res = (pos_b == BODY_LEN);

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    cent_nxt   = cent_r;
    year_nxt   = year_r;
    mon_nxt    = mon_r;
    day_nxt    = day_r;
    nondig_nxt = nondig_r;
    out_status_nxt = out_status_r;
    if (adv) begin
      pos_nxt    = pos_b;
      sum_nxt    = sum_b;
      cent_nxt   = cent_b;
      year_nxt   = year_b;
      mon_nxt    = mon_b;
      day_nxt    = day_b;
      nondig_nxt = nondig_b;
      if (pos_b < BODY_LEN) begin
        // body character: weighted sum and date digits
        sum_nxt = mod11(sum_raw);
        if (!is_digit) begin
          nondig_nxt = 1'b1;
        end
        if (pos_b == POS_CENT_HI || pos_b == POS_CENT_LO) begin
          cent_nxt = 7'((cent_b << 3) + (cent_b << 1) + 7'(digit));
        end else if (pos_b == POS_YEAR_HI || pos_b == POS_YEAR_LO) begin
          year_nxt = 7'((year_b << 3) + (year_b << 1) + 7'(digit));
        end else if (pos_b == POS_MON_HI || pos_b == POS_MON_LO) begin
          mon_nxt = 7'((mon_b << 3) + (mon_b << 1) + 7'(digit));
        end else if (pos_b == POS_DAY_HI || pos_b == POS_DAY_LO) begin
          day_nxt = 7'((day_b << 3) + (day_b << 1) + 7'(digit));
        end
        pos_nxt = pos_b + 5'd1;
      end else if (has_res) begin
        // check character: emit status, then ignore until next line start
        out_status_nxt[STAT_DATE_BIT] = date_bad;
        out_status_nxt[STAT_CODE_BIT] = nondig_b || (s1_char_r != check_char(sum_b));
        pos_nxt = ID_LEN;
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = in_valid ? 1'b1 : (s1_valid_r && !adv);
    out_valid_nxt = adv ? has_res : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      sum_r       <= '0;
      cent_r      <= '0;
      year_r      <= '0;
      mon_r       <= '0;
      day_r       <= '0;
      nondig_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= s1_valid_nxt;
      end
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      cent_r      <= cent_nxt;
      year_r      <= year_nxt;
      mon_r       <= mon_nxt;
      day_r       <= day_nxt;
      nondig_r    <= nondig_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r  <= in_char_code;
      s1_start_r <= in_line_start;
    end
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

@@ sv/nidv_sva.sv @@
`timescale 1ns / 1ps
// Port-level checker for the ID number validator, bound to the top level.
module nidv_sva
  import nidv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_char_code,
  input logic       in_line_start,
  input logic       out_valid,
  input logic       out_ready,
  input status_t    out_status
);

  // a waiting item holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=>
      in_valid && $stable(in_char_code) && $stable(in_line_start))
    else $error("input item changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new result must match an earlier accepted item
  a_res_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching item");

  // with no result waiting the block always takes an item
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind national_id_number_validator nidv_sva u_nidv_sva (.*);
